@@ hw/rtl/sorted_timeout_queue_assert.svh @@
// Assertion macros used by the checker file.
`ifndef SORTED_TIMEOUT_QUEUE_ASSERT_SVH
`define SORTED_TIMEOUT_QUEUE_ASSERT_SVH
// Implication checked at every rising edge outside reset.
`define STQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define STQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/stq_pkg.sv @@
package stq_pkg;
    localparam int NumSlots = 16;
    localparam int TickBits = 32;
    localparam int SlotBits = 4;
    localparam int CntBits = $clog2(NumSlots + 1);

    typedef enum logic [1:0] {
        ACT_ARM = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_EXPIRE = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        TMR_NONE = 2'd0,
        TMR_START = 2'd1,
        TMR_STOP = 2'd2
    } timer_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AGE,
        ST_DISPATCH,
        ST_EXPIRE,
        ST_SEARCH,
        ST_STATUS
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input item
        logic age_step;  // age one slot, index from the counter
        logic cnt_clear;
        logic exp_step;  // retire the list head on expiry
        logic exp_fin;   // close expiry, set timer command
        logic srch_step; // examine one list entry for insertion
        logic act_fin;   // arm/cancel/clear finalize
        logic emit_fire;
        logic emit_status;
    } stq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic age_done;
        logic is_expire;
        logic bad_slot;
        logic need_search;
        logic head_zero;  // list nonempty and head has zero ticks
        logic srch_done;  // search stop condition met on current entry
        logic out_busy;
    } stq_stat_t;
endpackage

@@ hw/rtl/stq_datapath.sv @@
module stq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  stq_pkg::stq_cmd_t   cmd,
    output stq_pkg::stq_stat_t  stat,
    input  logic [79:0]         in_data, // action, slot, delay_ticks, now_count
    output logic                out_valid,
    input  logic                out_ready,
    output logic [40:0]         out_data, // kind, result_slot, error, slot_done,
                                          // timer_cmd, timer_load
    output logic                out_last
);
    import stq_pkg::*;

    logic [TickBits-1:0] rem_reg [NumSlots];
    logic [SlotBits-1:0] nxt_reg [NumSlots];
    logic [SlotBits-1:0] prv_reg [NumSlots];
    logic [NumSlots-1:0] act_reg, done_reg;
    logic [SlotBits-1:0] head_reg, tail_reg;
    logic                ne_reg, trun_reg;
    logic [TickBits-1:0] saved_reg;

    logic [1:0]          op_reg;
    logic [3:0]          slot_reg;
    logic [TickBits-1:0] delay_reg, elapsed_reg;
    logic [CntBits-1:0]  cnt_reg;
    logic [SlotBits-1:0] cur_reg;
    logic                found_reg;
    logic                err_reg;
    logic [1:0]          tcmd_reg;
    logic [TickBits-1:0] tload_reg;

    logic                ovalid_reg, olast_reg;
    logic [40:0]         odata_reg;

    logic [SlotBits-1:0] s, ai;
    logic [TickBits-1:0] cur_rem;
    logic                cur_tail;

    assign s = slot_reg[SlotBits-1:0];
    assign ai = cnt_reg[SlotBits-1:0];
    assign cur_rem = rem_reg[cur_reg];
    assign cur_tail = (cur_reg == tail_reg);

    // Status toward the controller.
    always_comb
    begin
        stat.age_done = (cnt_reg == CntBits'(NumSlots));
        stat.is_expire = (op_reg == ACT_EXPIRE);
        stat.bad_slot = ({28'd0, slot_reg} >= 32'(NumSlots));
        stat.need_search = (op_reg == ACT_ARM) && !act_reg[s] && (delay_reg != '0) && ne_reg;
        stat.head_zero = ne_reg && (rem_reg[head_reg] == '0);
        stat.srch_done = (cur_rem >= delay_reg) || cur_tail;
        stat.out_busy = ovalid_reg && !out_ready;
    end

    // Item capture, aging, list maintenance, expiry and output emission.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
            done_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            ne_reg <= 1'b0;
            trun_reg <= 1'b0;
            saved_reg <= '0;
            cnt_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            if (cmd.load)
            begin
                op_reg <= in_data[1:0];
                slot_reg <= in_data[5:2];
                delay_reg <= in_data[37:6];
                elapsed_reg <= in_data[69:38] - saved_reg;
                saved_reg <= in_data[69:38];
                tcmd_reg <= TMR_NONE;
                tload_reg <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.cnt_clear)
                cnt_reg <= '0;
            if (cmd.age_step)
            begin
                if (act_reg[ai])
                    rem_reg[ai] <= (rem_reg[ai] > elapsed_reg) ?
                                   rem_reg[ai] - elapsed_reg : '0;
                cnt_reg <= cnt_reg + 1'b1;
                cur_reg <= head_reg;
            end
            if (cmd.exp_step)
            begin
                act_reg[head_reg] <= 1'b0;
                done_reg[head_reg] <= 1'b1;
                cur_reg <= head_reg;
                if (head_reg == tail_reg)
                    ne_reg <= 1'b0;
                head_reg <= nxt_reg[head_reg];
            end
            if (cmd.exp_fin && ne_reg)
            begin
                trun_reg <= 1'b1;
                tcmd_reg <= TMR_START;
                tload_reg <= rem_reg[head_reg];
            end
            else if (cmd.exp_fin && trun_reg)
            begin
                trun_reg <= 1'b0;
                tcmd_reg <= TMR_STOP;
            end
            if (cmd.srch_step)
            begin
                if (cur_rem >= delay_reg)
                    found_reg <= 1'b1;
                else if (!cur_tail)
                    cur_reg <= nxt_reg[cur_reg];
            end
            if (cmd.act_fin)
            begin
                // The error flag reflects the slot state before the action.
                err_reg <= ((op_reg == ACT_ARM) && act_reg[s])
                    || ((op_reg == ACT_CANCEL) && !act_reg[s]);
                unique case (op_reg)
                    ACT_ARM:
                    begin
                        if (!act_reg[s])
                        begin
                            if (delay_reg == '0)
                                done_reg[s] <= 1'b1;
                            else
                            begin
                                rem_reg[s] <= delay_reg;
                                act_reg[s] <= 1'b1;
                                if (!ne_reg)
                                begin
                                    head_reg <= s;
                                    tail_reg <= s;
                                    ne_reg <= 1'b1;
                                    trun_reg <= 1'b1;
                                    tcmd_reg <= TMR_START;
                                    tload_reg <= delay_reg;
                                end
                                else if (found_reg)
                                begin
                                    nxt_reg[s] <= cur_reg;
                                    prv_reg[s] <= prv_reg[cur_reg];
                                    prv_reg[cur_reg] <= s;
                                    if (cur_reg == head_reg)
                                    begin
                                        head_reg <= s;
                                        trun_reg <= 1'b1;
                                        tcmd_reg <= TMR_START;
                                        tload_reg <= delay_reg;
                                    end
                                    else
                                        nxt_reg[prv_reg[cur_reg]] <= s;
                                end
                                else
                                begin
                                    nxt_reg[tail_reg] <= s;
                                    prv_reg[s] <= tail_reg;
                                    tail_reg <= s;
                                end
                            end
                        end
                    end
                    ACT_CANCEL:
                    begin
                        if (act_reg[s])
                        begin
                            if (s == head_reg)
                            begin
                                if (s == tail_reg)
                                begin
                                    ne_reg <= 1'b0;
                                    trun_reg <= 1'b0;
                                    tcmd_reg <= TMR_STOP;
                                end
                                else
                                begin
                                    head_reg <= nxt_reg[s];
                                    trun_reg <= 1'b1;
                                    tcmd_reg <= TMR_START;
                                    tload_reg <= rem_reg[nxt_reg[s]];
                                end
                            end
                            else if (s == tail_reg)
                                tail_reg <= prv_reg[s];
                            else
                            begin
                                nxt_reg[prv_reg[s]] <= nxt_reg[s];
                                prv_reg[nxt_reg[s]] <= prv_reg[s];
                            end
                            act_reg[s] <= 1'b0;
                        end
                    end
                    ACT_CLEAR:
                        done_reg[s] <= 1'b0;
                    default:
                        ;
                endcase
            end
            if (cmd.emit_fire)
            begin
                ovalid_reg <= 1'b1;
                olast_reg <= 1'b0;
                odata_reg <= {32'd0, 2'd0, 1'b1, 1'b0, cur_reg, 1'b1};
            end
            if (cmd.emit_status)
            begin
                ovalid_reg <= 1'b1;
                olast_reg <= 1'b1;
                if (op_reg == ACT_EXPIRE)
                    odata_reg <= {tload_reg, tcmd_reg, 1'b0, 1'b0, 4'd0, 1'b0};
                else if (stat.bad_slot)
                    odata_reg <= {32'd0, 2'd0, 1'b0, 1'b1, slot_reg, 1'b0};
                else
                    odata_reg <= {tload_reg, tcmd_reg, done_reg[s], err_reg,
                        slot_reg, 1'b0};
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data = odata_reg;
    assign out_last = olast_reg;
endmodule

@@ hw/rtl/stq_ctrl.sv @@
module stq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output stq_pkg::stq_cmd_t   cmd,
    input  stq_pkg::stq_stat_t  stat
);
    import stq_pkg::*;

    state_t state_reg, state_next;
    logic   fired_reg, fired_next;
    logic   stat_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fired_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fired_reg <= fired_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        fired_next = fired_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_AGE;
            ST_AGE:
                if (stat.age_done)
                    state_next = ST_DISPATCH;
            ST_DISPATCH:
                if (stat.is_expire)
                    state_next = ST_EXPIRE;
                else if (!stat.bad_slot && stat.need_search)
                    state_next = ST_SEARCH;
                else
                    state_next = ST_STATUS;
            ST_EXPIRE:
                if (fired_reg)
                begin
                    if (!stat.out_busy)
                        fired_next = 1'b0;
                end
                else if (stat.head_zero)
                    fired_next = 1'b1;
                else if (!stat.out_busy)
                    state_next = ST_IDLE;
            ST_SEARCH:
                if (stat.srch_done)
                    state_next = ST_STATUS;
            ST_STATUS:
                if (!stat.out_busy)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd = '0;
        cmd.emit_status = stat_pend_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                cmd.cnt_clear = in_valid;
            end
            ST_AGE:
                cmd.age_step = !stat.age_done;
            ST_DISPATCH:
                ;
            ST_EXPIRE:
                if (fired_reg)
                    cmd.emit_fire = !stat.out_busy;
                else if (stat.head_zero)
                    cmd.exp_step = 1'b1;
                else if (!stat.out_busy)
                begin
                    cmd.exp_fin = 1'b1;
                end
            ST_SEARCH:
                cmd.srch_step = 1'b1;
            ST_STATUS:
                if (!stat.out_busy)
                begin
                    cmd.act_fin = !stat.bad_slot;
                end
            default:
                ;
        endcase
    end

    // Status emission follows in the cycle after finalize or a bad-slot status state, via a late flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stat_pend_reg <= 1'b0;
        else
            stat_pend_reg <= cmd.act_fin || cmd.exp_fin
                || (state_reg == ST_STATUS && !stat.out_busy && stat.bad_slot);
    end
endmodule

@@ hw/rtl/sorted_timeout_queue.sv @@
// Sorted one-shot timeout queue with sixteen slots.
// Each item is aged first, and aging visits one slot per cycle; an insert search then
// walks the sorted list entry by entry, and an expire retires and reports each fired
// slot from the list head before the status item closes the output.
// One item at a time: a new item is accepted only once the previous one has finished.
// Reset (rst_n low, asynchronous): all slots idle, list empty, timer stopped.
module sorted_timeout_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata, // action, slot, delay_ticks, now_count, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata, // result_slot, error, slot_done, timer_cmd,
                                 // timer_load
    output logic        m_tuser, // kind
    output logic        m_tlast
);
    import stq_pkg::*;

    stq_cmd_t   cmd;
    stq_stat_t  stat;
    logic [40:0] raw;
    logic        busy_q;

    stq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(busy_q),
        .cmd(cmd), .stat(stat)
    );
    assign s_tready = busy_q;

    stq_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_data({8'd0, s_tdata}), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(raw), .out_last(m_tlast)
    );

    // Drop the kind bit into tuser and pass the rest as tdata.
    assign m_tuser = raw[0];
    assign m_tdata = raw[40:1];
endmodule

@@ hw/rtl/stq_checker.sv @@
module stq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tuser,
    input logic        m_tlast
);
`include "sorted_timeout_queue_assert.svh"
    // A fired notice is never the closing item.
    `STQ_ASSERT_IMP(a_fire_not_last, clk, rst_n, m_tvalid && m_tuser, !m_tlast)
    // A status item always closes.
    `STQ_ASSERT_IMP(a_status_last, clk, rst_n, m_tvalid && !m_tuser, m_tlast)
    // Input is not taken right after an accept.
    `STQ_ASSERT_NXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // A waiting result stays offered until it is taken.
    `STQ_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
endmodule

bind sorted_timeout_queue stq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

@@ sim/tb_sorted_timeout_queue.sv @@
module tb_sorted_timeout_queue;
    import stq_pkg::*;

    localparam int IdleLimit = 5000;
    localparam int HoldCycles = 800;
    localparam int HoldAtItem = 80;

    typedef struct packed {
        action_t     action;
        logic [3:0]  slot;
        logic [31:0] delay_ticks;
        logic [31:0] now_count;
    } timer_req_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic        error;
        logic        slot_done;
        timer_cmd_t  cmd;
        logic [31:0] load;
        logic        last;
    } timer_note_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    sorted_timeout_queue uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    timer_req_t  pending_reqs[$];
    timer_note_t expected_notes[$];
    timer_req_t  cur_req;
    int          items_accepted = 0;
    int          notes_seen = 0;
    int          mismatches = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          idle_cycles = 0;
    int          rx_phase = 0;

    // Shadow copy of the queue state.
    logic [31:0] q_rem [16];
    logic        q_active [16];
    logic        q_done [16];
    logic [3:0]  q_next [16];
    logic [3:0]  q_prev [16];
    logic [3:0]  q_head;
    logic [3:0]  q_tail;
    logic        q_nonempty;
    logic [31:0] q_saved;

    task automatic push_note(input logic kind, input logic [3:0] slot, input logic err,
                             input logic done, input timer_cmd_t cmd,
                             input logic [31:0] load, input logic last);
        timer_note_t n;
        n.kind = kind;
        n.slot = slot;
        n.error = err;
        n.slot_done = done;
        n.cmd = cmd;
        n.load = load;
        n.last = last;
        expected_notes.push_back(n);
    endtask

    // Age all armed slots, apply the action and queue the expected results.
    task automatic predict_timeouts(input timer_req_t r);
        logic [31:0] elapsed;
        logic [3:0]  c;
        logic [3:0]  nx;
        logic [3:0]  s;
        timer_cmd_t  cmd;
        logic [31:0] load;
        logic        err;
        bit          found;
        elapsed = r.now_count - q_saved;
        q_saved = r.now_count;
        s = r.slot;
        cmd = TMR_NONE;
        load = '0;
        err = 1'b0;
        for (int i = 0; i < 16; i++)
            if (q_active[i])
                q_rem[i] = (q_rem[i] > elapsed) ? q_rem[i] - elapsed : 32'd0;
        case (r.action)
            ACT_EXPIRE:
            begin
                if (q_nonempty)
                begin
                    c = q_head;
                    for (int i = 0; i < 16 && q_nonempty && q_rem[c] == 0; i++)
                    begin
                        nx = q_next[c];
                        q_active[c] = 1'b0;
                        q_done[c] = 1'b1;
                        push_note(1'b1, c, 1'b0, 1'b1, TMR_NONE, 32'd0, 1'b0);
                        if (c == q_tail)
                            q_nonempty = 1'b0;
                        c = nx;
                    end
                    if (q_nonempty)
                    begin
                        q_head = c;
                        cmd = TMR_START;
                        load = q_rem[c];
                    end
                    else
                        cmd = TMR_STOP;
                end
                push_note(1'b0, 4'd0, 1'b0, 1'b0, cmd, load, 1'b1);
                return;
            end
            ACT_ARM:
            begin
                if (q_active[s])
                    err = 1'b1;
                else if (r.delay_ticks == 0)
                    q_done[s] = 1'b1;
                else
                begin
                    q_rem[s] = r.delay_ticks;
                    if (!q_nonempty)
                    begin
                        q_head = s;
                        q_tail = s;
                        q_nonempty = 1'b1;
                        cmd = TMR_START;
                        load = r.delay_ticks;
                    end
                    else
                    begin
                        c = q_head;
                        found = 1'b0;
                        for (int i = 0; i < 16; i++)
                        begin
                            if (q_rem[c] >= r.delay_ticks)
                            begin
                                found = 1'b1;
                                break;
                            end
                            if (c == q_tail)
                                break;
                            c = q_next[c];
                        end
                        if (found)
                        begin
                            q_next[s] = c;
                            q_prev[s] = q_prev[c];
                            if (c == q_head)
                            begin
                                q_head = s;
                                cmd = TMR_START;
                                load = r.delay_ticks;
                            end
                            else
                                q_next[q_prev[c]] = s;
                            q_prev[c] = s;
                        end
                        else
                        begin
                            q_next[q_tail] = s;
                            q_prev[s] = q_tail;
                            q_tail = s;
                        end
                    end
                    q_active[s] = 1'b1;
                end
            end
            ACT_CANCEL:
            begin
                if (!q_active[s])
                    err = 1'b1;
                else
                begin
                    if (s == q_head)
                    begin
                        if (s == q_tail)
                        begin
                            q_nonempty = 1'b0;
                            cmd = TMR_STOP;
                        end
                        else
                        begin
                            q_head = q_next[s];
                            cmd = TMR_START;
                            load = q_rem[q_head];
                        end
                    end
                    else if (s == q_tail)
                        q_tail = q_prev[s];
                    else
                    begin
                        q_next[q_prev[s]] = q_next[s];
                        q_prev[q_next[s]] = q_prev[s];
                    end
                    q_active[s] = 1'b0;
                end
            end
            default:
                q_done[s] = 1'b0;
        endcase
        push_note(1'b0, s, err, q_done[s], cmd, load, 1'b1);
    endtask

    // Sender: bursts of items separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_timeouts(cur_req);
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata <= {2'b00, cur_req.now_count, cur_req.delay_ticks,
                                cur_req.slot, cur_req.action};
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stretches of full readiness, random stalls, one long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_phase++;
            if (!hold_done && items_accepted >= HoldAtItem)
            begin
                hold_done = 1'b1;
                hold_left = HoldCycles;
                m_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_phase[8])
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        timer_note_t got;
        timer_note_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.slot = m_tdata[3:0];
            got.error = m_tdata[4];
            got.slot_done = m_tdata[5];
            got.cmd = timer_cmd_t'(m_tdata[7:6]);
            got.load = m_tdata[39:8];
            got.last = m_tlast;
            notes_seen++;
            if (expected_notes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = expected_notes.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %p, got %p", notes_seen, want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any input or output transfer.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("sorted_timeout_queue test failed");
            $finish;
        end
    end

    logic [31:0] stim_now = 0;

    task automatic add_req(input action_t a, input logic [3:0] s, input logic [31:0] d,
                           input logic [31:0] n);
        timer_req_t r;
        r.action = a;
        r.slot = s;
        r.delay_ticks = d;
        r.now_count = n;
        pending_reqs.push_back(r);
    endtask

    // Random traffic with a slowly advancing counter, plus occasional noise.
    task automatic add_random(input int count);
        int      pick;
        action_t a;
        logic [31:0] d;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                a = ACT_ARM;
            else if (pick < 65)
                a = ACT_EXPIRE;
            else if (pick < 85)
                a = ACT_CANCEL;
            else
                a = ACT_CLEAR;
            case ($urandom_range(0, 9))
                0: d = 32'd0;
                1: d = $urandom;
                default: d = $urandom_range(1, 300);
            endcase
            if ($urandom_range(0, 19) == 0)
                stim_now = $urandom;
            else
                stim_now = stim_now + $urandom_range(0, 60);
            add_req(a, 4'($urandom_range(0, 15)), d, stim_now);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
        begin
            q_rem[i] = '0;
            q_active[i] = 1'b0;
            q_done[i] = 1'b0;
            q_next[i] = '0;
            q_prev[i] = '0;
        end
        q_head = '0;
        q_tail = '0;
        q_nonempty = 1'b0;
        q_saved = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cases.
        add_req(ACT_EXPIRE, 4'd0, 32'd0, 32'd0);           // expire on empty list
        add_req(ACT_ARM, 4'd0, 32'd0, 32'd0);              // zero delay marks done
        add_req(ACT_ARM, 4'd1, 32'd100, 32'd0);
        add_req(ACT_ARM, 4'd1, 32'd5, 32'd0);              // arm of armed slot
        add_req(ACT_ARM, 4'd2, 32'd50, 32'd0);             // new head
        add_req(ACT_ARM, 4'd3, 32'hffffffff, 32'd0);       // goes to the tail
        add_req(ACT_ARM, 4'd15, 32'd70, 32'd0);            // middle insert
        add_req(ACT_CANCEL, 4'd5, 32'd0, 32'd0);           // cancel of idle slot
        add_req(ACT_CANCEL, 4'd15, 32'd0, 32'd0);          // middle removal
        add_req(ACT_CANCEL, 4'd3, 32'd0, 32'd0);           // tail removal
        add_req(ACT_CANCEL, 4'd2, 32'd0, 32'd0);           // head removal
        add_req(ACT_CLEAR, 4'd0, 32'd0, 32'd0);
        add_req(ACT_CLEAR, 4'd1, 32'd0, 32'd0);            // armed slot stays queued
        add_req(ACT_EXPIRE, 4'd0, 32'd0, 32'd10);          // nothing at zero
        add_req(ACT_EXPIRE, 4'd0, 32'd0, 32'd10);          // equal counter readings
        add_req(ACT_EXPIRE, 4'd0, 32'd0, 32'd200);         // fires slot 1, stops
        add_req(ACT_ARM, 4'd4, 32'd10, 32'hfffffff0);
        add_req(ACT_ARM, 4'd6, 32'd10, 32'hfffffff0);
        add_req(ACT_ARM, 4'd7, 32'd40, 32'hfffffff0);
        add_req(ACT_EXPIRE, 4'd0, 32'd0, 32'd5);           // wrap, two fire, restart
        add_req(ACT_CANCEL, 4'd7, 32'd0, 32'd5);           // last entry, stop
        add_req(ACT_ARM, 4'd8, 32'hffffffff, 32'hffffffff);
        add_req(ACT_CANCEL, 4'd8, 32'd0, 32'h0);
        stim_now = 32'd100;

        add_random(70);
        // Let everything drain before continuing.
        while (pending_reqs.size() != 0 || s_tvalid || expected_notes.size() != 0)
            @(posedge clk);
        add_random(90);

        while (pending_reqs.size() != 0 || s_tvalid || expected_notes.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_notes.size() == 0)
            $display("sorted_timeout_queue test passed");
        else
            $display("sorted_timeout_queue test failed");
        $finish;
    end

endmodule
